[rtl/gci_pkg.sv]
// gci_pkg: shared constants for the gpio controller
// command codes, register word indexes and parameter defaults
// no dependencies
package gci_pkg;

   // payload widths fixed by the bus
   localparam int CMD_W  = 2;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // parameter defaults
   localparam int                NUM_PINS_DEFAULT      = 32;
   localparam int                PERIOD_BITS_DEFAULT   = 24;
   localparam logic [DATA_W-1:0] VERSION_VALUE_DEFAULT = 32'h0000_0000;

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

   // register word indexes (byte offset / 4)
   localparam logic [ADDR_W-1:0] REG_VERSION   = 5'd0;
   localparam logic [ADDR_W-1:0] REG_DATA_OUT  = 5'd1;
   localparam logic [ADDR_W-1:0] REG_DATA_IN   = 5'd2;
   localparam logic [ADDR_W-1:0] REG_DIRECTION = 5'd3;
   localparam logic [ADDR_W-1:0] REG_SET       = 5'd5;
   localparam logic [ADDR_W-1:0] REG_CLEAR     = 5'd6;
   localparam logic [ADDR_W-1:0] REG_PULL_EN   = 5'd7;
   localparam logic [ADDR_W-1:0] REG_PULL_KIND = 5'd8;
   localparam logic [ADDR_W-1:0] REG_IRQ_EN    = 5'd9;
   localparam logic [ADDR_W-1:0] REG_RAW_STAT  = 5'd10;
   localparam logic [ADDR_W-1:0] REG_MASK_STAT = 5'd11;
   localparam logic [ADDR_W-1:0] REG_MASK      = 5'd12;
   localparam logic [ADDR_W-1:0] REG_W1C       = 5'd13;
   localparam logic [ADDR_W-1:0] REG_TRIG_LVL  = 5'd14;
   localparam logic [ADDR_W-1:0] REG_TRIG_BOTH = 5'd15;
   localparam logic [ADDR_W-1:0] REG_TRIG_POL  = 5'd16;
   localparam logic [ADDR_W-1:0] REG_FILT_EN   = 5'd17;
   localparam logic [ADDR_W-1:0] REG_FILT_PER  = 5'd18;

endpackage

[rtl/gci_req_if.sv]
// gci_req_if: request channel of the gpio controller
// valid/ready handshake carrying one bus access or one pin-sampling tick
// depends on gci_pkg
interface gci_req_if;
   logic                         valid;
   logic                         ready;
   logic [gci_pkg::CMD_W-1:0]    command;
   logic [gci_pkg::ADDR_W-1:0]   address;
   logic [gci_pkg::DATA_W-1:0]   write_data;
   logic [gci_pkg::DATA_W-1:0]   pins_sampled;

   modport source (output valid, command, address, write_data, pins_sampled, input ready);
   modport sink   (input valid, command, address, write_data, pins_sampled, output ready);
endinterface

[rtl/gci_rsp_if.sv]
// gci_rsp_if: response channel of the gpio controller
// valid/ready handshake carrying read data, pin drive state and irq
// depends on gci_pkg
interface gci_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gci_pkg::DATA_W-1:0]   read_data;
   logic [gci_pkg::DATA_W-1:0]   pins_drive;
   logic [gci_pkg::DATA_W-1:0]   pins_enable;
   logic                         irq;

   modport source (output valid, read_data, pins_drive, pins_enable, irq, input ready);
   modport sink   (input valid, read_data, pins_drive, pins_enable, irq, output ready);
endinterface

[rtl/gci_debounce.sv]
// gci_debounce: per-pin input debounce with one stability counter per pin
// holds the filtered pin levels; updates only on a sample strobe
// depends on gci_pkg for parameter defaults
module gci_debounce #(
   parameter int NUM_PINS    = gci_pkg::NUM_PINS_DEFAULT,
   parameter int PERIOD_BITS = gci_pkg::PERIOD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   sample_en,
   input  logic [NUM_PINS-1:0]    sample,
   input  logic [NUM_PINS-1:0]    filter_enable,
   input  logic [PERIOD_BITS-1:0] period,
   output logic [NUM_PINS-1:0]    filtered,
   output logic [NUM_PINS-1:0]    filtered_next
);

   logic [PERIOD_BITS-1:0] count_ff [NUM_PINS];
   logic [PERIOD_BITS-1:0] count_in [NUM_PINS];
   logic [NUM_PINS-1:0]    filtered_ff;
   logic [PERIOD_BITS-1:0] limit;

   // a zero period behaves as one
   assign limit = (period == '0) ? PERIOD_BITS'(1) : period;

   always_comb begin
      logic [PERIOD_BITS-1:0] bumped;
      for (int i = 0; i < NUM_PINS; i++) begin
         bumped = (count_ff[i] == '1) ? count_ff[i] : count_ff[i] + PERIOD_BITS'(1);
         count_in[i]      = count_ff[i];
         filtered_next[i] = filtered_ff[i];
         if (sample_en) begin
            if (!filter_enable[i]) begin
               count_in[i]      = '0;
               filtered_next[i] = sample[i];
            end else if (sample[i] == filtered_ff[i]) begin
               count_in[i] = '0;
            end else if (bumped >= limit) begin
               count_in[i]      = '0;
               filtered_next[i] = sample[i];
            end else begin
               count_in[i] = bumped;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filtered_ff <= '0;
         for (int i = 0; i < NUM_PINS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         filtered_ff <= filtered_next;
         for (int i = 0; i < NUM_PINS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign filtered = filtered_ff;

endmodule

[rtl/gpio_controller_with_interrupts.sv]
// GPIO controller with per-pin interrupts and input debounce. Every request
// transfer is a register read, a register write or a tick that samples the
// pins; each one gives exactly one response transfer, carrying read data
// (zero except on reads of readable words), the current pin drive values,
// the output enables and the interrupt request as they stand after that
// request. Throughput is one request per clock while responses are taken:
// a request lands in an input register, is executed against the register
// file and the debounce counters once the output register can advance, and
// its response is presented from the output register. The input register
// lets a new request be taken while a response waits on the response side.
// depends on gci_pkg, gci_req_if, gci_rsp_if and gci_debounce
module gpio_controller_with_interrupts #(
   parameter int                        NUM_PINS      = gci_pkg::NUM_PINS_DEFAULT,
   parameter int                        PERIOD_BITS   = gci_pkg::PERIOD_BITS_DEFAULT,
   parameter logic [gci_pkg::DATA_W-1:0] VERSION_VALUE = gci_pkg::VERSION_VALUE_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   gci_req_if.sink    req_bus,
   gci_rsp_if.source  rsp_bus
);

   localparam int DW = gci_pkg::DATA_W;

   // input register
   logic                        in_valid_ff;
   logic [gci_pkg::CMD_W-1:0]   cmd_ff;
   logic [gci_pkg::ADDR_W-1:0]  addr_ff;
   logic [DW-1:0]               wdata_ff;
   logic [DW-1:0]               pins_ff;

   // output register
   logic                        out_valid_ff;
   logic [DW-1:0]               rdata_ff, rdata_in;

   // register file
   logic [NUM_PINS-1:0] out_data_ff, out_data_in;
   logic [NUM_PINS-1:0] direction_ff, direction_in;
   logic [NUM_PINS-1:0] pull_en_ff, pull_en_in;
   logic [NUM_PINS-1:0] pull_kind_ff, pull_kind_in;
   logic [NUM_PINS-1:0] irq_en_ff, irq_en_in;
   logic [NUM_PINS-1:0] irq_raw_ff, irq_raw_in;
   logic [NUM_PINS-1:0] mask_ff, mask_in;
   logic [NUM_PINS-1:0] trig_lvl_ff, trig_lvl_in;
   logic [NUM_PINS-1:0] trig_both_ff, trig_both_in;
   logic [NUM_PINS-1:0] trig_pol_ff, trig_pol_in;
   logic [NUM_PINS-1:0] filt_en_ff, filt_en_in;
   logic [PERIOD_BITS-1:0] filt_per_ff, filt_per_in;

   logic                advance, execute, do_tick;
   logic [NUM_PINS-1:0] wpins;
   logic [NUM_PINS-1:0] filtered, filtered_next;
   logic [NUM_PINS-1:0] rise, fall, edge_hit, active, raw_edge;

   assign advance = !out_valid_ff || rsp_bus.ready;
   assign execute = in_valid_ff && advance;
   assign do_tick = execute && (cmd_ff == gci_pkg::CMD_TICK);
   assign req_bus.ready = !in_valid_ff || advance;

   gci_debounce #(
      .NUM_PINS    (NUM_PINS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_debounce (
      .clock         (clock),
      .reset         (reset),
      .sample_en     (do_tick),
      .sample        (pins_ff[NUM_PINS-1:0]),
      .filter_enable (filt_en_ff),
      .period        (filt_per_ff),
      .filtered      (filtered),
      .filtered_next (filtered_next)
   );

   assign wpins = wdata_ff[NUM_PINS-1:0];

   // interrupt detection on the debounced levels
   assign rise     = ~filtered & filtered_next;
   assign fall     = filtered & ~filtered_next;
   assign edge_hit = (trig_both_ff & (rise | fall)) |
                     (~trig_both_ff & ((trig_pol_ff & fall) | (~trig_pol_ff & rise)));
   assign raw_edge = irq_raw_ff | (edge_hit & ~trig_lvl_ff & irq_en_ff);
   assign active   = filtered_next ^ trig_pol_ff;

   always_comb begin
      out_data_in  = out_data_ff;
      direction_in = direction_ff;
      pull_en_in   = pull_en_ff;
      pull_kind_in = pull_kind_ff;
      irq_en_in    = irq_en_ff;
      irq_raw_in   = irq_raw_ff;
      mask_in      = mask_ff;
      trig_lvl_in  = trig_lvl_ff;
      trig_both_in = trig_both_ff;
      trig_pol_in  = trig_pol_ff;
      filt_en_in   = filt_en_ff;
      filt_per_in  = filt_per_ff;
      rdata_in     = rdata_ff;
      if (execute) begin
         rdata_in = '0;
         unique case (cmd_ff)
            gci_pkg::CMD_TICK: begin
               // level pins follow the live level, edge pins stay sticky
               irq_raw_in = (raw_edge & ~trig_lvl_ff) | (trig_lvl_ff & irq_en_ff & active);
            end
            gci_pkg::CMD_READ: begin
               unique case (addr_ff)
                  gci_pkg::REG_VERSION:   rdata_in = VERSION_VALUE;
                  gci_pkg::REG_DATA_OUT:  rdata_in = DW'(out_data_ff);
                  gci_pkg::REG_DATA_IN:   rdata_in = DW'(filtered);
                  gci_pkg::REG_DIRECTION: rdata_in = DW'(direction_ff);
                  gci_pkg::REG_PULL_EN:   rdata_in = DW'(pull_en_ff);
                  gci_pkg::REG_PULL_KIND: rdata_in = DW'(pull_kind_ff);
                  gci_pkg::REG_IRQ_EN:    rdata_in = DW'(irq_en_ff);
                  gci_pkg::REG_RAW_STAT:  rdata_in = DW'(irq_raw_ff);
                  gci_pkg::REG_MASK_STAT: rdata_in = DW'(irq_raw_ff & ~mask_ff);
                  gci_pkg::REG_MASK:      rdata_in = DW'(mask_ff);
                  gci_pkg::REG_TRIG_LVL:  rdata_in = DW'(trig_lvl_ff);
                  gci_pkg::REG_TRIG_BOTH: rdata_in = DW'(trig_both_ff);
                  gci_pkg::REG_TRIG_POL:  rdata_in = DW'(trig_pol_ff);
                  gci_pkg::REG_FILT_EN:   rdata_in = DW'(filt_en_ff);
                  gci_pkg::REG_FILT_PER:  rdata_in = DW'(filt_per_ff);
                  default:                rdata_in = '0;
               endcase
            end
            gci_pkg::CMD_WRITE: begin
               unique case (addr_ff)
                  gci_pkg::REG_DATA_OUT:  out_data_in  = wpins;
                  gci_pkg::REG_DIRECTION: direction_in = wpins;
                  gci_pkg::REG_SET:       out_data_in  = out_data_ff | wpins;
                  gci_pkg::REG_CLEAR:     out_data_in  = out_data_ff & ~wpins;
                  gci_pkg::REG_PULL_EN:   pull_en_in   = wpins;
                  gci_pkg::REG_PULL_KIND: pull_kind_in = wpins;
                  gci_pkg::REG_IRQ_EN:    irq_en_in    = wpins;
                  gci_pkg::REG_MASK:      mask_in      = wpins;
                  gci_pkg::REG_W1C:       irq_raw_in   = irq_raw_ff & ~wpins;
                  gci_pkg::REG_TRIG_LVL:  trig_lvl_in  = wpins;
                  gci_pkg::REG_TRIG_BOTH: trig_both_in = wpins;
                  gci_pkg::REG_TRIG_POL:  trig_pol_in  = wpins;
                  gci_pkg::REG_FILT_EN:   filt_en_in   = wpins;
                  gci_pkg::REG_FILT_PER:  filt_per_in  = wdata_ff[PERIOD_BITS-1:0];
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_data_ff  <= '0;
         direction_ff <= '0;
         pull_en_ff   <= '0;
         pull_kind_ff <= '0;
         irq_en_ff    <= '0;
         irq_raw_ff   <= '0;
         mask_ff      <= '1;
         trig_lvl_ff  <= '0;
         trig_both_ff <= '0;
         trig_pol_ff  <= '0;
         filt_en_ff   <= '0;
         filt_per_ff  <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         out_data_ff  <= out_data_in;
         direction_ff <= direction_in;
         pull_en_ff   <= pull_en_in;
         pull_kind_ff <= pull_kind_in;
         irq_en_ff    <= irq_en_in;
         irq_raw_ff   <= irq_raw_in;
         mask_ff      <= mask_in;
         trig_lvl_ff  <= trig_lvl_in;
         trig_both_ff <= trig_both_in;
         trig_pol_ff  <= trig_pol_in;
         filt_en_ff   <= filt_en_in;
         filt_per_ff  <= filt_per_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         cmd_ff   <= req_bus.command;
         addr_ff  <= req_bus.address;
         wdata_ff <= req_bus.write_data;
         pins_ff  <= req_bus.pins_sampled;
      end
      rdata_ff <= rdata_in;
   end

   // state only moves when the response register loads, so it is the post-request view
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.read_data   = rdata_ff;
   assign rsp_bus.pins_drive  = DW'(out_data_ff);
   assign rsp_bus.pins_enable = DW'(direction_ff);
   assign rsp_bus.irq         = |(irq_raw_ff & ~mask_ff);

endmodule
